### rtl/core/recs80_pkg.sv
// Shared types and constants for the RECS80 infrared frame decoder.
package recs80_pkg;

   localparam int DUR_WIDTH   = 16;
   localparam int VALUE_WIDTH = 9;
   localparam int IDX_WIDTH   = 5;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [IDX_WIDTH-1:0] IDX_MAX = 5'd31;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_MARK_LOW        = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MARK_HIGH       = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ONE_SPACE_LOW   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ONE_SPACE_HIGH  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ZERO_SPACE_LOW  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ZERO_SPACE_HIGH = 3'd5;

   localparam logic [DUR_WIDTH-1:0] RST_MARK_LOW        = 16'd3;
   localparam logic [DUR_WIDTH-1:0] RST_MARK_HIGH       = 16'd7;
   localparam logic [DUR_WIDTH-1:0] RST_ONE_SPACE_LOW   = 16'd109;
   localparam logic [DUR_WIDTH-1:0] RST_ONE_SPACE_HIGH  = 16'd184;
   localparam logic [DUR_WIDTH-1:0] RST_ZERO_SPACE_LOW  = 16'd72;
   localparam logic [DUR_WIDTH-1:0] RST_ZERO_SPACE_HIGH = 16'd121;

   typedef struct packed {
      logic [DUR_WIDTH-1:0] mark_low;
      logic [DUR_WIDTH-1:0] mark_high;
      logic [DUR_WIDTH-1:0] one_space_low;
      logic [DUR_WIDTH-1:0] one_space_high;
      logic [DUR_WIDTH-1:0] zero_space_low;
      logic [DUR_WIDTH-1:0] zero_space_high;
   } cfg_type;

   typedef struct packed {
      logic                   frame_ok;
      logic [VALUE_WIDTH-1:0] decoded_value;
   } result_type;

endpackage

### rtl/core/recs80_csr.sv
// Window register file written through the configuration channel.
module recs80_csr
   import recs80_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DUR_WIDTH-1:0]     csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MARK_LOW:        cfg_in.mark_low        = csr_data;
            REG_MARK_HIGH:       cfg_in.mark_high       = csr_data;
            REG_ONE_SPACE_LOW:   cfg_in.one_space_low   = csr_data;
            REG_ONE_SPACE_HIGH:  cfg_in.one_space_high  = csr_data;
            REG_ZERO_SPACE_LOW:  cfg_in.zero_space_low  = csr_data;
            REG_ZERO_SPACE_HIGH: cfg_in.zero_space_high = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_low        <= RST_MARK_LOW;
         cfg_ff.mark_high       <= RST_MARK_HIGH;
         cfg_ff.one_space_low   <= RST_ONE_SPACE_LOW;
         cfg_ff.one_space_high  <= RST_ONE_SPACE_HIGH;
         cfg_ff.zero_space_low  <= RST_ZERO_SPACE_LOW;
         cfg_ff.zero_space_high <= RST_ZERO_SPACE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/recs80_frame.sv
// Frame state and per-entry window matching with bit shifting.
module recs80_frame
   import recs80_pkg::*;
#(
   parameter int DATA_BITS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 advance,
   input  logic [DUR_WIDTH-1:0] duration_ticks,
   input  logic                 frame_end,
   output result_type           result,
   output logic [IDX_WIDTH-1:0] entry_index
);

   localparam logic [IDX_WIDTH-1:0] DATA_END   = IDX_WIDTH'(2 + 2 * DATA_BITS);
   localparam logic [IDX_WIDTH-1:0] FINAL_MARK = IDX_WIDTH'(3 + 2 * DATA_BITS);
   localparam int WIDE_WIDTH = (DATA_BITS > VALUE_WIDTH) ? DATA_BITS : VALUE_WIDTH;

   logic [IDX_WIDTH-1:0] index_ff, index_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in, shift_new;
   logic                 failed_ff, failed_in, failed_new;
   logic                 mark_hit, one_hit, zero_hit;
   logic                 frame_ok;
   logic [WIDE_WIDTH-1:0] wide_value;

   assign mark_hit = (duration_ticks >= cfg.mark_low) && (duration_ticks <= cfg.mark_high);
   assign one_hit  = (duration_ticks >= cfg.one_space_low)
                     && (duration_ticks <= cfg.one_space_high);
   assign zero_hit = (duration_ticks >= cfg.zero_space_low)
                     && (duration_ticks <= cfg.zero_space_high);

   always_comb begin
      shift_new  = shift_ff;
      failed_new = failed_ff;
      if (index_ff == 5'd1) begin
         if (!mark_hit) failed_new = 1'b1;
      end else if (index_ff == 5'd2) begin
         if (!one_hit) failed_new = 1'b1;
      end else if (index_ff >= 5'd3 && index_ff <= DATA_END) begin
         if (index_ff[0]) begin
            if (!mark_hit) failed_new = 1'b1;
         end else if (one_hit) begin
            shift_new = DATA_BITS'({shift_ff, 1'b1});
         end else if (zero_hit) begin
            shift_new = DATA_BITS'({shift_ff, 1'b0});
         end else begin
            failed_new = 1'b1;
         end
      end else if (index_ff == FINAL_MARK) begin
         if (!mark_hit) failed_new = 1'b1;
      end
   end

   assign frame_ok   = !failed_new && (index_ff >= FINAL_MARK);
   assign wide_value = WIDE_WIDTH'(shift_new);

   assign result.frame_ok      = frame_ok;
   assign result.decoded_value = frame_ok ? wide_value[VALUE_WIDTH-1:0] : '0;
   assign entry_index          = index_ff;

   always_comb begin
      index_in  = index_ff;
      shift_in  = shift_ff;
      failed_in = failed_ff;
      if (advance) begin
         if (frame_end) begin
            index_in  = '0;
            shift_in  = '0;
            failed_in = 1'b0;
         end else begin
            index_in  = (index_ff < IDX_MAX) ? index_ff + 5'd1 : index_ff;
            shift_in  = shift_new;
            failed_in = failed_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         shift_ff  <= '0;
         failed_ff <= 1'b0;
      end else begin
         index_ff  <= index_in;
         shift_ff  <= shift_in;
         failed_ff <= failed_in;
      end
   end

endmodule

### rtl/core/recs80_ir_frame_decoder_top.sv
// Top level of the RECS80 infrared frame decoder.
//
// Channel  Direction  Beat contents
// req_     in         tdata: duration_ticks; tlast: frame_end
// rsp_     out        tdata: decoded_value; tuser: frame_ok
// csr_     in         csr_index: register number; csr_data: value
//
// One entry per cycle unless a frame_end entry stalls: input register, window compares, result register.
// A result is loaded at the edge its frame_end entry leaves the input register.
// An entry without frame_end never stalls; a frame_end entry waits only while
// the result register still holds an untaken result.
// Reset (synchronous) clears frame state and restores the default windows.
module recs80_ir_frame_decoder_top
   import recs80_pkg::*;
#(
   parameter int DATA_BITS = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [15:0] duration_ticks
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // [8:0] decoded_value, [15:9] zero
   output logic                     rsp_tuser,   // [0] frame_ok
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DUR_WIDTH-1:0]     csr_data
);

   cfg_type              cfg;
   result_type           result;
   logic [IDX_WIDTH-1:0] entry_index;

   logic                 in_valid_ff, in_valid_in;
   logic [DUR_WIDTH-1:0] in_dur_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   logic                 advance;
   logic                 out_free;

   recs80_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   recs80_frame #(
      .DATA_BITS (DATA_BITS)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .advance        (advance),
      .duration_ticks (in_dur_ff),
      .frame_end      (in_last_ff),
      .result         (result),
      .entry_index    (entry_index)
   );

   assign out_free    = !out_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_dur_ff  <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = 16'(out_ff.decoded_value);
   assign rsp_tuser  = out_ff.frame_ok;

`ifndef SYNTH
   a_fail_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("failed frame carries a non-zero value");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_dur_ff) && $stable(in_last_ff))
      else $error("stalled entry lost from input register");

   a_frame_rearm: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> entry_index == '0)
      else $error("frame state not cleared after frame end");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_tvalid)
      else $error("frame end beat produced no result");
`endif

endmodule
